>>> sv/wls_pkg.sv
// Shared types, constants and the arctangent table for the waypoint steering block.
// Used by every module of the block but wls_ram; depends on nothing.
package wls_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int COORD_W    = 16;
  localparam int YAW_W      = 15;
  localparam int DIST_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int SPD_W      = 16;
  localparam int TIDX_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ATAN_STEPS = 16;
  localparam int ITER_W     = 4;
  localparam int Z_W        = 22;
  localparam int CX_W       = 32;
  localparam int ANG_W      = Z_W - 4;
  localparam int ERR_W      = ANG_W + 1;

  localparam logic signed [Z_W-1:0] PI_Q16 = 22'sd205887;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD = 3'd0,
    CFG_GOAL      = 3'd1,
    CFG_GAIN      = 3'd2,
    CFG_THRESH    = 3'd3,
    CFG_VSTEP     = 3'd4,
    CFG_VMAX      = 3'd5,
    CFG_DRIVE_EN  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0] lookahead_dist;
    logic [DIST_W-1:0] goal_dist;
    logic [GAIN_W-1:0] steer_gain;
    logic [DIST_W-1:0] turn_threshold;
    logic [SPD_W-1:0]  vel_step;
    logic [SPD_W-1:0]  vel_max;
    logic              drive_enable;
  } cfg_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic                      run;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [YAW_W-1:0]   yaw;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_SQ, ST_CMP, ST_AINIT, ST_ATAN,
    ST_ERR, ST_GAIN, ST_MUL, ST_SAT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_TGT, PH_SRCH, PH_PICK
  } phase_t;

  // arctangent of 2^-i, radians * 65536
  function automatic logic [Z_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      4'd0:    v = 22'd51472;
      4'd1:    v = 22'd30386;
      4'd2:    v = 22'd16055;
      4'd3:    v = 22'd8150;
      4'd4:    v = 22'd4091;
      4'd5:    v = 22'd2047;
      4'd6:    v = 22'd1024;
      4'd7:    v = 22'd512;
      4'd8:    v = 22'd256;
      4'd9:    v = 22'd128;
      4'd10:   v = 22'd64;
      4'd11:   v = 22'd32;
      4'd12:   v = 22'd16;
      4'd13:   v = 22'd8;
      4'd14:   v = 22'd4;
      default: v = 22'd2;
    endcase
    return v;
  endfunction

endpackage

>>> sv/wls_if.sv
// Channel interfaces: command input, drive output and configuration write.
// Depends on wls_pkg for field widths.
interface wls_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         command;
  logic signed [wls_pkg::COORD_W-1:0] waypoint_x;
  logic signed [wls_pkg::COORD_W-1:0] waypoint_y;
  logic                               run_request;
  logic signed [wls_pkg::COORD_W-1:0] pose_x;
  logic signed [wls_pkg::COORD_W-1:0] pose_y;
  logic signed [wls_pkg::YAW_W-1:0]   pose_yaw;
  modport source (output valid, command, waypoint_x, waypoint_y, run_request,
                  pose_x, pose_y, pose_yaw, input ready);
  modport sink (input valid, command, waypoint_x, waypoint_y, run_request,
                pose_x, pose_y, pose_yaw, output ready);
endinterface

interface wls_out_if;
  logic                               valid;
  logic                               ready;
  logic [wls_pkg::SPD_W-1:0]          linear_speed;
  logic signed [15:0]                 angular_speed;
  logic                               drive_valid;
  logic [wls_pkg::TIDX_W-1:0]         target_index;
  logic                               mission_running;
  logic                               table_empty;
  modport source (output valid, linear_speed, angular_speed, drive_valid,
                  target_index, mission_running, table_empty, input ready);
  modport sink (input valid, linear_speed, angular_speed, drive_valid,
                target_index, mission_running, table_empty, output ready);
endinterface

interface wls_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wls_pkg::CFG_IDX_W-1:0]     index;
  logic [wls_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/wls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/wls_front.sv
// Front end: accepts command items, decodes them and holds them in a two-entry queue.
// Depends on wls_pkg and wls_in_if.
module wls_front (
  input  logic           clk,
  input  logic           rst,
  wls_in_if.sink         cmd_in,
  output wls_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);

  wls_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  wls_pkg::item_t dec;

  assign cmd_in.ready = (fill != 2'd2);
  assign push         = cmd_in.valid && cmd_in.ready;
  assign q_valid      = (fill != 2'd0);
  assign q_item       = slot[rd_ptr];

  // decode the command code and carry the payload
  always_comb begin
    dec.cmd = wls_pkg::cmd_t'(cmd_in.command);
    dec.wx  = cmd_in.waypoint_x;
    dec.wy  = cmd_in.waypoint_y;
    dec.run = cmd_in.run_request;
    dec.px  = cmd_in.pose_x;
    dec.py  = cmd_in.pose_y;
    dec.yaw = cmd_in.pose_yaw;
  end

  // store on transfer
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2) else $error("queue fill out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 && !push) |=> fill == 2'd0) else $error("queue filled without push");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !cmd_in.ready) else $error("ready while full");
`endif

endmodule

>>> sv/wls_back.sv
// Back end: waypoint table, goal advance, lookahead search, CORDIC atan2 and speed law.
// Depends on wls_pkg, wls_ram and wls_out_if.
module wls_back #(
  parameter int MAX_WAYPOINTS = wls_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  wls_pkg::cfg_t  cfg,
  input  wls_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  wls_out_if.source      drv_out
);

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  wls_pkg::state_t state, state_next;
  wls_pkg::phase_t phase;

  logic [CW-1:0] cnt;
  logic [IW-1:0] tgt, srch, idx;
  logic          running;
  logic [15:0]   ramp;

  logic signed [wls_pkg::COORD_W-1:0] px, py;
  logic signed [wls_pkg::YAW_W-1:0]   yaw;
  logic [2*wls_pkg::DIST_W-1:0]       gd_sq, ld_sq;

  logic signed [wls_pkg::COORD_W-1:0] rx, ry;
  logic signed [wls_pkg::COORD_W:0]   dx, dy, dx_r, dy_r;
  logic [2*wls_pkg::COORD_W+1:0]      sq_x, sq_y;
  logic [2*wls_pkg::COORD_W+2:0]      dsum;

  logic signed [wls_pkg::CX_W-1:0]    cx, cy, xs, ys;
  logic signed [wls_pkg::Z_W-1:0]     cz;
  logic [wls_pkg::ITER_W-1:0]         iter;

  logic signed [wls_pkg::ERR_W-1:0]   err_r;
  logic signed [wls_pkg::ANG_W-1:0]   ang_q;
  logic [wls_pkg::ERR_W-1:0]          mag;
  logic                               turn, turn_r;
  logic signed [wls_pkg::ERR_W+17:0]  prod;
  logic signed [wls_pkg::ERR_W+6:0]   ang_rnd;

  logic [wls_pkg::SPD_W-1:0] res_lin;
  logic signed [15:0]        res_ang;
  logic                      res_empty;

  logic [CW-1:0] last_w;
  logic [IW-1:0] last;
  logic          near;
  logic          run_after;
  logic [IW-1:0] tgt_after;
  logic          ram_we, ram_re;
  logic [CW-1:0] idx_inc;

  assign last_w  = cnt - CW'(1);
  assign last    = last_w[IW-1:0];
  assign ram_we  = (state == wls_pkg::ST_IDLE) && q_valid &&
                   (q_item.cmd == wls_pkg::CMD_APPEND) && (cnt < CW'(MAX_WAYPOINTS));
  assign ram_re  = (state == wls_pkg::ST_RD);
  assign q_pop   = (state == wls_pkg::ST_IDLE) && q_valid;
  assign idx_inc = {1'b0, idx} + CW'(1);

  wls_ram #(.WIDTH(wls_pkg::COORD_W), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(cnt[IW-1:0]), .wdata(q_item.wx),
    .re(ram_re), .raddr(idx), .rdata(rx)
  );
  wls_ram #(.WIDTH(wls_pkg::COORD_W), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(cnt[IW-1:0]), .wdata(q_item.wy),
    .re(ram_re), .raddr(idx), .rdata(ry)
  );

  // offsets and squared distance
  assign dx   = {rx[wls_pkg::COORD_W-1], rx} - {px[wls_pkg::COORD_W-1], px};
  assign dy   = {ry[wls_pkg::COORD_W-1], ry} - {py[wls_pkg::COORD_W-1], py};
  assign dsum = {1'b0, sq_x} + {1'b0, sq_y};
  assign near = dsum < {5'b0, gd_sq};

  // goal advance outcome
  always_comb begin
    run_after = running;
    tgt_after = tgt;
    if (near) begin
      if (tgt == last) begin
        run_after = 1'b0;
      end else begin
        tgt_after = tgt + IW'(1);
      end
    end
  end

  // CORDIC step shifts
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;

  // heading error magnitude and turn decision
  assign mag  = err_r[wls_pkg::ERR_W-1] ? wls_pkg::ERR_W'(-err_r) : wls_pkg::ERR_W'(err_r);
  assign turn = mag > {{(wls_pkg::ERR_W-wls_pkg::DIST_W){1'b0}}, cfg.turn_threshold};

  // round half away from zero by 2^12
  assign ang_rnd = prod[wls_pkg::ERR_W+17]
                 ? -(wls_pkg::ERR_W+7)'(((-prod) + 2048) >>> 12)
                 :  (wls_pkg::ERR_W+7)'((prod + 2048) >>> 12);

  // rounded atan2 in Q3.12
  assign ang_q = cz[wls_pkg::Z_W-1]
               ? -wls_pkg::ANG_W'(((-cz) + 8) >>> 4)
               :  wls_pkg::ANG_W'((cz + 8) >>> 4);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wls_pkg::ST_IDLE: begin
        if (q_valid && q_item.cmd == wls_pkg::CMD_TICK) begin
          state_next = (cnt == '0) ? wls_pkg::ST_OUT : wls_pkg::ST_RD;
        end
      end
      wls_pkg::ST_RD:  state_next = wls_pkg::ST_SQ;
      wls_pkg::ST_SQ:  state_next = wls_pkg::ST_CMP;
      wls_pkg::ST_CMP: begin
        case (phase)
          wls_pkg::PH_TGT:
            state_next = (run_after && cfg.drive_enable) ? wls_pkg::ST_RD : wls_pkg::ST_OUT;
          wls_pkg::PH_SRCH:
            state_next = (dsum > {5'b0, ld_sq}) ? wls_pkg::ST_AINIT : wls_pkg::ST_RD;
          default: state_next = wls_pkg::ST_AINIT;
        endcase
      end
      wls_pkg::ST_AINIT:
        state_next = (dx_r == '0 && dy_r == '0) ? wls_pkg::ST_ERR : wls_pkg::ST_ATAN;
      wls_pkg::ST_ATAN: begin
        if (iter == wls_pkg::ITER_W'(wls_pkg::ATAN_STEPS - 1)) begin
          state_next = wls_pkg::ST_ERR;
        end
      end
      wls_pkg::ST_ERR:  state_next = wls_pkg::ST_GAIN;
      wls_pkg::ST_GAIN: state_next = wls_pkg::ST_MUL;
      wls_pkg::ST_MUL:  state_next = wls_pkg::ST_SAT;
      wls_pkg::ST_SAT:  state_next = wls_pkg::ST_OUT;
      wls_pkg::ST_OUT: begin
        if (!drv_out.valid || drv_out.ready) begin
          state_next = wls_pkg::ST_IDLE;
        end
      end
      default: state_next = wls_pkg::ST_IDLE;
    endcase
  end

  // control state: table, target, search start, mission and ramp
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      tgt     <= '0;
      srch    <= '0;
      running <= 1'b0;
      ramp    <= '0;
    end else begin
      case (state)
        wls_pkg::ST_IDLE: begin
          if (q_valid) begin
            case (q_item.cmd)
              wls_pkg::CMD_CLEAR: begin
                cnt  <= '0;
                tgt  <= '0;
                srch <= '0;
              end
              wls_pkg::CMD_APPEND: begin
                if (cnt < CW'(MAX_WAYPOINTS)) begin
                  cnt <= cnt + CW'(1);
                end
              end
              wls_pkg::CMD_RUN: running <= q_item.run;
              default: begin
                if (cnt != '0 && {1'b0, tgt} > last_w) begin
                  tgt <= last;
                end
              end
            endcase
          end
        end
        wls_pkg::ST_CMP: begin
          case (phase)
            wls_pkg::PH_TGT: begin
              running <= run_after;
              tgt     <= tgt_after;
            end
            wls_pkg::PH_SRCH: begin
              if (dsum > {5'b0, ld_sq}) begin
                srch <= idx;
                tgt  <= idx;
              end
            end
            default: tgt <= idx;
          endcase
        end
        wls_pkg::ST_GAIN: begin
          if (turn) begin
            ramp <= '0;
          end else if (ramp != 16'hFFFF) begin
            ramp <= ramp + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      wls_pkg::ST_IDLE: begin
        px        <= q_item.px;
        py        <= q_item.py;
        yaw       <= q_item.yaw;
        gd_sq     <= cfg.goal_dist * cfg.goal_dist;
        ld_sq     <= cfg.lookahead_dist * cfg.lookahead_dist;
        phase     <= wls_pkg::PH_TGT;
        res_lin   <= '0;
        res_ang   <= '0;
        res_empty <= (cnt == '0);
        idx       <= ({1'b0, tgt} > last_w) ? last : tgt;
      end
      wls_pkg::ST_SQ: begin
        sq_x <= (2*wls_pkg::COORD_W+2)'(dx * dx);
        sq_y <= (2*wls_pkg::COORD_W+2)'(dy * dy);
        dx_r <= dx;
        dy_r <= dy;
      end
      wls_pkg::ST_CMP: begin
        case (phase)
          wls_pkg::PH_TGT: begin
            if ({1'b0, srch} < last_w) begin
              idx   <= srch;
              phase <= wls_pkg::PH_SRCH;
            end else begin
              idx   <= last;
              phase <= wls_pkg::PH_PICK;
            end
          end
          wls_pkg::PH_SRCH: begin
            if (!(dsum > {5'b0, ld_sq})) begin
              if (idx_inc < last_w) begin
                idx <= idx_inc[IW-1:0];
              end else begin
                idx   <= last;
                phase <= wls_pkg::PH_PICK;
              end
            end
          end
          default: ;
        endcase
      end
      wls_pkg::ST_AINIT: begin
        iter <= '0;
        if (dx_r[wls_pkg::COORD_W]) begin
          cx <= -(wls_pkg::CX_W'(dx_r) <<< 12);
          cy <= -(wls_pkg::CX_W'(dy_r) <<< 12);
          cz <= dy_r[wls_pkg::COORD_W] ? -wls_pkg::PI_Q16 : wls_pkg::PI_Q16;
        end else begin
          cx <= wls_pkg::CX_W'(dx_r) <<< 12;
          cy <= wls_pkg::CX_W'(dy_r) <<< 12;
          cz <= '0;
        end
      end
      wls_pkg::ST_ATAN: begin
        iter <= iter + wls_pkg::ITER_W'(1);
        if (!cy[wls_pkg::CX_W-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + $signed(wls_pkg::atan_step(iter));
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - $signed(wls_pkg::atan_step(iter));
        end
      end
      wls_pkg::ST_ERR: begin
        err_r <= wls_pkg::ERR_W'(ang_q) - wls_pkg::ERR_W'(yaw);
      end
      wls_pkg::ST_GAIN: turn_r <= turn;
      wls_pkg::ST_MUL: begin
        if (turn_r) begin
          prod <= err_r * $signed({1'b0, cfg.steer_gain});
        end else begin
          prod <= $signed({{(wls_pkg::ERR_W-16){1'b0}}, ramp}) * $signed({1'b0, cfg.vel_step});
        end
      end
      wls_pkg::ST_SAT: begin
        if (turn_r) begin
          res_lin <= '0;
          if (ang_rnd > 32767) begin
            res_ang <= 16'sh7FFF;
          end else if (ang_rnd < -32768) begin
            res_ang <= -16'sh8000;
          end else begin
            res_ang <= ang_rnd[15:0];
          end
        end else begin
          res_ang <= '0;
          res_lin <= (prod < (wls_pkg::ERR_W+18)'($signed({1'b0, cfg.vel_max})))
                   ? prod[15:0] : cfg.vel_max;
        end
      end
      default: ;
    endcase
  end

  // output register: load on completion, drop on transfer
  logic [IW+wls_pkg::TIDX_W-1:0] tgt_ext;
  assign tgt_ext = {{wls_pkg::TIDX_W{1'b0}}, tgt};

  always_ff @(posedge clk) begin
    if (rst) begin
      drv_out.valid <= 1'b0;
    end else if (state == wls_pkg::ST_OUT && (!drv_out.valid || drv_out.ready)) begin
      drv_out.valid <= 1'b1;
    end else if (drv_out.ready) begin
      drv_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wls_pkg::ST_OUT && (!drv_out.valid || drv_out.ready)) begin
      drv_out.linear_speed    <= res_lin;
      drv_out.angular_speed   <= res_ang;
      drv_out.drive_valid     <= cfg.drive_enable;
      drv_out.target_index    <= tgt_ext[wls_pkg::TIDX_W-1:0];
      drv_out.mission_running <= running;
      drv_out.table_empty     <= res_empty;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_WAYPOINTS)) else $error("waypoint count beyond table");
  a_srch_in_table: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) || ({1'b0, srch} < cnt)) else $error("search start beyond table");
  a_cordic_len: assert property (@(posedge clk) disable iff (rst)
    (state == wls_pkg::ST_ATAN && iter == wls_pkg::ITER_W'(wls_pkg::ATAN_STEPS - 1))
      |=> state == wls_pkg::ST_ERR) else $error("CORDIC step count wrong");
  a_turn_ramp: assert property (@(posedge clk) disable iff (rst)
    (state == wls_pkg::ST_GAIN && turn) |=> ramp == '0) else $error("ramp not reset on turn");
`endif

endmodule

>>> sv/waypoint_lookahead_steering_top.sv
// Waypoint follower top level: configuration registers, front queue and back engine.
// Depends on wls_pkg, wls_if, wls_front and wls_back.
//
//  channel  | dir | contents
//  cmd_in   | in  | command, waypoint_x/y, run_request, pose_x/y, pose_yaw
//  drv_out  | out | linear_speed, angular_speed, drive_valid, target_index, status
//  cfg      | in  | index, data (always ready)
//
// Clear, append and run commands are handled in the idle state of the back engine. A pose
// tick reads the target, each waypoint scanned and, when none lies beyond lookahead, the
// last one; each read passes the read, square and compare states, and the CORDIC loop is
// skipped for a zero offset. A tick without drive reads only the target, one on an empty
// table nothing. Reset is synchronous; the table holds garbage until written. A stalled
// output holds one result while the two-entry queue takes commands until it is full.
module waypoint_lookahead_steering_top #(
  parameter int MAX_WAYPOINTS = wls_pkg::MAX_WAYPOINTS_DEF
) (
  input logic      clk,
  input logic      rst,
  wls_in_if.sink   cmd_in,
  wls_out_if.source drv_out,
  wls_cfg_if.sink  cfg
);

  wls_pkg::cfg_t  cfg_regs;
  wls_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.lookahead_dist <= 15'd256;
      cfg_regs.goal_dist      <= 15'd51;
      cfg_regs.steer_gain     <= 16'd4096;
      cfg_regs.turn_threshold <= 15'd410;
      cfg_regs.vel_step       <= 16'd655;
      cfg_regs.vel_max        <= 16'd17039;
      cfg_regs.drive_enable   <= 1'b1;
    end else if (cfg.valid) begin
      case (wls_pkg::cfg_idx_t'(cfg.index))
        wls_pkg::CFG_LOOKAHEAD: cfg_regs.lookahead_dist <= cfg.data[14:0];
        wls_pkg::CFG_GOAL:      cfg_regs.goal_dist      <= cfg.data[14:0];
        wls_pkg::CFG_GAIN:      cfg_regs.steer_gain     <= cfg.data;
        wls_pkg::CFG_THRESH:    cfg_regs.turn_threshold <= cfg.data[14:0];
        wls_pkg::CFG_VSTEP:     cfg_regs.vel_step       <= cfg.data;
        wls_pkg::CFG_VMAX:      cfg_regs.vel_max        <= cfg.data;
        wls_pkg::CFG_DRIVE_EN:  cfg_regs.drive_enable   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  wls_front u_front (
    .clk(clk), .rst(rst), .cmd_in(cmd_in),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  wls_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg_regs),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop), .drv_out(drv_out)
  );

endmodule
